@@ rtl/core/tas_pkg.sv @@
// ----------------------------------------------------------------------------
// Tray action sequencer package
// Shared types, command codes and the step tables of the tray actions.
// ----------------------------------------------------------------------------
package tas_pkg;

   localparam int POS_W       = 32;
   localparam int WAIT_W      = 16;
   localparam int STEP_W      = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int QDEPTH      = 4;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [WAIT_W-1:0] MIN_WAIT_RESET = 16'd1000;
   localparam logic [STEP_W-1:0] LOAD_WAIT_STEP = 3'd1;

   typedef enum logic [2:0] {
      KIND_TICK       = 3'd0,
      KIND_INIT       = 3'd1,
      KIND_PLACE      = 3'd2,
      KIND_LOAD       = 3'd3,
      KIND_ESTOP      = 3'd4,
      KIND_LOAD_DONE  = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      CMD_NONE   = 3'd0,
      CMD_CLOSE  = 3'd1,
      CMD_HOME   = 3'd2,
      CMD_MOVE   = 3'd3,
      CMD_OPEN   = 3'd4,
      CMD_STOP   = 3'd5,
      CMD_STATUS = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_INIT  = 2'd1,
      ACT_PLACE = 2'd2,
      ACT_LOAD  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      POS_NONE    = 2'd0,
      POS_DEFAULT = 2'd1,
      POS_PLACE   = 2'd2,
      POS_LOAD    = 2'd3
   } pos_sel_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEFAULT_POS = 3'd0,
      CSR_PLACE_POS   = 3'd1,
      CSR_LOAD_POS    = 3'd2,
      CSR_MIN_WAIT    = 3'd3,
      CSR_FAKE_MOTION = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic              is_wait;
      cmd_type           cmd;
      pos_sel_type       pos;
   } step_type;

   typedef struct packed {
      logic signed [POS_W-1:0] default_position;
      logic signed [POS_W-1:0] place_position;
      logic signed [POS_W-1:0] load_position;
      logic [WAIT_W-1:0]       min_wait_ms;
      logic                    fake_motion;
   } cfg_type;

   typedef struct packed {
      cmd_type                 command;
      logic signed [POS_W-1:0] target_position;
      logic                    accepted;
      logic                    initialized;
      logic                    last;
   } rsp_item_type;

   typedef struct packed {
      logic         push;
      logic         push_two;
      rsp_item_type item0;
      rsp_item_type item1;
   } queue_push_type;

   function automatic logic [STEP_W-1:0] seq_length(input action_type act);
      logic [STEP_W-1:0] len;
      unique case (act)
         ACT_INIT:  len = 3'd3;
         ACT_PLACE: len = 3'd4;
         ACT_LOAD:  len = 3'd3;
         default:   len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic step_type seq_step(input action_type act,
                                         input logic [STEP_W-1:0] idx);
      step_type st;
      st = '{is_wait: 1'b0, cmd: CMD_NONE, pos: POS_NONE};
      unique case (act)
         ACT_INIT: begin
            unique case (idx)
               3'd0:    st = '{is_wait: 1'b0, cmd: CMD_CLOSE, pos: POS_NONE};
               3'd1:    st = '{is_wait: 1'b0, cmd: CMD_HOME, pos: POS_NONE};
               3'd2:    st = '{is_wait: 1'b0, cmd: CMD_MOVE, pos: POS_DEFAULT};
               default: st = '{is_wait: 1'b0, cmd: CMD_NONE, pos: POS_NONE};
            endcase
         end
         ACT_PLACE: begin
            unique case (idx)
               3'd0:    st = '{is_wait: 1'b0, cmd: CMD_MOVE, pos: POS_PLACE};
               3'd1:    st = '{is_wait: 1'b0, cmd: CMD_OPEN, pos: POS_NONE};
               3'd2:    st = '{is_wait: 1'b0, cmd: CMD_MOVE, pos: POS_DEFAULT};
               3'd3:    st = '{is_wait: 1'b0, cmd: CMD_CLOSE, pos: POS_NONE};
               default: st = '{is_wait: 1'b0, cmd: CMD_NONE, pos: POS_NONE};
            endcase
         end
         ACT_LOAD: begin
            unique case (idx)
               3'd0:    st = '{is_wait: 1'b0, cmd: CMD_MOVE, pos: POS_LOAD};
               3'd1:    st = '{is_wait: 1'b1, cmd: CMD_NONE, pos: POS_NONE};
               3'd2:    st = '{is_wait: 1'b0, cmd: CMD_MOVE, pos: POS_DEFAULT};
               default: st = '{is_wait: 1'b0, cmd: CMD_NONE, pos: POS_NONE};
            endcase
         end
         default: st = '{is_wait: 1'b0, cmd: CMD_NONE, pos: POS_NONE};
      endcase
      return st;
   endfunction

endpackage

@@ rtl/core/tas_csr.sv @@
// ----------------------------------------------------------------------------
// Tray action sequencer configuration registers
// Holds the tray positions, the minimum wait and the fake motion switch.
// ----------------------------------------------------------------------------
module tas_csr
   import tas_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [POS_W-1:0]       csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEFAULT_POS: cfg_in.default_position = csr_data;
            CSR_PLACE_POS:   cfg_in.place_position   = csr_data;
            CSR_LOAD_POS:    cfg_in.load_position    = csr_data;
            CSR_MIN_WAIT:    cfg_in.min_wait_ms      = csr_data[WAIT_W-1:0];
            CSR_FAKE_MOTION: cfg_in.fake_motion      = csr_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_position <= '0;
         cfg_ff.place_position   <= '0;
         cfg_ff.load_position    <= '0;
         cfg_ff.min_wait_ms      <= MIN_WAIT_RESET;
         cfg_ff.fake_motion      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/core/tas_core.sv @@
// ----------------------------------------------------------------------------
// Tray action sequencer core
// Sequence state and the per-event step logic; yields one or two results.
// ----------------------------------------------------------------------------
module tas_core
   import tas_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [2:0]        kind,
   input  logic [WAIT_W-1:0] elapsed_ms,
   input  logic              lifter_idle,
   input  logic              link_up,
   input  cfg_type           cfg,
   output queue_push_type    push
);

   action_type        action_ff, action_in;
   logic [STEP_W-1:0] step_idx_ff, step_idx_in;
   logic              running_ff, running_in;
   logic              load_done_ff, load_done_in;
   logic              ready_ff, ready_in;
   logic [WAIT_W-1:0] timer_ff, timer_in;

   logic [WAIT_W:0]   timer_sum;
   logic [WAIT_W-1:0] timer_sat;
   logic [STEP_W-1:0] len;
   step_type          step_a, step_b;
   logic              adv_a, emit_a, emit_b, accepted;
   cmd_type           cmd_a, cmd_b;
   logic signed [POS_W-1:0] pos_a, pos_b;

   function automatic logic signed [POS_W-1:0] pos_value(input pos_sel_type sel,
                                                         input cfg_type c);
      logic signed [POS_W-1:0] v;
      unique case (sel)
         POS_DEFAULT: v = c.default_position;
         POS_PLACE:   v = c.place_position;
         POS_LOAD:    v = c.load_position;
         default:     v = '0;
      endcase
      return v;
   endfunction

   assign timer_sum = {1'b0, timer_ff} + {1'b0, elapsed_ms};
   assign timer_sat = timer_sum[WAIT_W] ? '1 : timer_sum[WAIT_W-1:0];
   assign len       = seq_length(action_ff);

   always_comb begin
      action_in    = action_ff;
      step_idx_in  = step_idx_ff;
      running_in   = running_ff;
      load_done_in = load_done_ff;
      ready_in     = ready_ff;
      timer_in     = timer_ff;
      step_a       = seq_step(action_ff, step_idx_ff);
      step_b       = step_a;
      adv_a        = 1'b0;
      emit_a       = 1'b0;
      emit_b       = 1'b0;
      cmd_a        = CMD_NONE;
      cmd_b        = CMD_NONE;
      pos_a        = '0;
      pos_b        = '0;
      accepted     = 1'b0;
      if (take) begin
         unique case (kind_type'(kind))
            KIND_TICK: begin
               timer_in = timer_sat;
               if (action_ff != ACT_NONE) begin
                  if (step_idx_ff < len) begin
                     if (step_a.is_wait) begin
                        if (!running_ff) begin
                           running_in = 1'b1;
                        end else if (load_done_ff) begin
                           step_idx_in  = step_idx_ff + STEP_W'(1);
                           load_done_in = 1'b0;
                           running_in   = 1'b0;
                           adv_a        = 1'b1;
                        end
                     end else if (!running_ff) begin
                        emit_a     = link_up;
                        cmd_a      = step_a.cmd;
                        pos_a      = pos_value(step_a.pos, cfg);
                        running_in = 1'b1;
                        timer_in   = '0;
                     end else begin
                        emit_a = link_up;
                        cmd_a  = CMD_STATUS;
                        if (timer_sat > cfg.min_wait_ms &&
                            ((link_up && lifter_idle) || cfg.fake_motion)) begin
                           running_in  = 1'b0;
                           step_idx_in = step_idx_ff + STEP_W'(1);
                           adv_a       = 1'b1;
                        end
                     end
                  end
                  if (adv_a && step_idx_in < len) begin
                     step_b     = seq_step(action_ff, step_idx_in);
                     running_in = 1'b1;
                     if (!step_b.is_wait) begin
                        emit_b   = link_up;
                        cmd_b    = step_b.cmd;
                        pos_b    = pos_value(step_b.pos, cfg);
                        timer_in = '0;
                     end
                  end
                  if (step_idx_in == len) begin
                     action_in = ACT_NONE;
                     if (action_ff == ACT_INIT) begin
                        ready_in = 1'b1;
                     end
                  end
               end
            end
            KIND_INIT: begin
               action_in   = ACT_INIT;
               step_idx_in = '0;
               accepted    = 1'b1;
            end
            KIND_PLACE, KIND_LOAD: begin
               if (ready_ff || cfg.fake_motion) begin
                  action_in   = (kind_type'(kind) == KIND_PLACE) ? ACT_PLACE : ACT_LOAD;
                  step_idx_in = '0;
                  accepted    = 1'b1;
               end
            end
            KIND_ESTOP: begin
               action_in   = ACT_NONE;
               step_idx_in = '0;
               running_in  = 1'b0;
               emit_a      = link_up;
               cmd_a       = CMD_STOP;
            end
            KIND_LOAD_DONE: begin
               if (action_ff == ACT_LOAD && step_idx_ff == LOAD_WAIT_STEP) begin
                  load_done_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      push.push     = take;
      push.push_two = emit_a && emit_b;
      priority if (emit_a) begin
         push.item0.command         = cmd_a;
         push.item0.target_position = pos_a;
      end else if (emit_b) begin
         push.item0.command         = cmd_b;
         push.item0.target_position = pos_b;
      end else begin
         push.item0.command         = CMD_NONE;
         push.item0.target_position = '0;
      end
      push.item0.accepted         = accepted;
      push.item0.initialized      = ready_in;
      push.item0.last             = !(emit_a && emit_b);
      push.item1.command          = cmd_b;
      push.item1.target_position  = pos_b;
      push.item1.accepted         = accepted;
      push.item1.initialized      = ready_in;
      push.item1.last             = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         action_ff    <= ACT_NONE;
         step_idx_ff  <= '0;
         running_ff   <= 1'b0;
         load_done_ff <= 1'b0;
         ready_ff     <= 1'b0;
         timer_ff     <= '0;
      end else begin
         action_ff    <= action_in;
         step_idx_ff  <= step_idx_in;
         running_ff   <= running_in;
         load_done_ff <= load_done_in;
         ready_ff     <= ready_in;
         timer_ff     <= timer_in;
      end
   end

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (action_ff != ACT_NONE) |-> (step_idx_ff <= seq_length(action_ff)))
      else $error("Step index is beyond the length of the running action.");

   a_ready_sticks: assert property (@(posedge clock) disable iff (reset)
      ready_ff |=> ready_ff)
      else $error("Tray lost its initialized flag without a reset.");

   a_load_done_in_load: assert property (@(posedge clock) disable iff (reset)
      $rose(load_done_ff) |-> (action_ff == ACT_LOAD && step_idx_ff == LOAD_WAIT_STEP))
      else $error("Load complete was latched outside the load wait step.");

endmodule

@@ rtl/core/tas_queue.sv @@
// ----------------------------------------------------------------------------
// Tray action sequencer result queue
// Small queue that takes up to two results a cycle and sends one a cycle while not stalled.
// ----------------------------------------------------------------------------
module tas_queue
   import tas_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_push_type push,
   output logic           space_two,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_item_type   rsp_item
);

   rsp_item_type      mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;

   assign space_two = (count_ff <= QCNT_W'(QDEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push.push) begin
         wr_ptr_in = wr_ptr_ff + (push.push_two ? QPTR_W'(2) : QPTR_W'(1));
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      count_in = count_ff + QCNT_W'(push.push) + QCNT_W'(push.push && push.push_two)
                 - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         mem_ff[wr_ptr_ff] <= push.item0;
         if (push.push_two) begin
            mem_ff[wr_ptr_ff + QPTR_W'(1)] <= push.item1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("Result queue holds more entries than its depth.");

   a_pair_whole: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.last) |-> (count_ff >= QCNT_W'(2)))
      else $error("First result of a pair is queued without its partner.");

   a_stalled_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)))
      else $error("A stalled result transfer changed or was dropped.");

endmodule

@@ rtl/core/tray_action_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// Tray action sequencer
// Steps a lifter tray through initialize, place and load actions.
// ----------------------------------------------------------------------------
// The results of an event are written to the result queue when it is transferred.
// Throughput: one event per cycle while the result queue has room for two results;
// the result side sends one result per cycle while rsp_stall is low, so events
// giving two results fill the queue and then stall further requests.
// Reset is synchronous and clears the sequence state, the result queue and
// returns the configuration registers to their defaults.
module tray_action_sequencer_unit
   import tas_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_kind,
   input  logic [WAIT_W-1:0]       req_elapsed_ms,
   input  logic                    req_lifter_idle,
   input  logic                    req_link_up,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_command,
   output logic signed [POS_W-1:0] rsp_target_position,
   output logic                    rsp_accepted,
   output logic                    rsp_initialized,
   output logic                    rsp_last,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [POS_W-1:0]        csr_data
);

   cfg_type        cfg;
   queue_push_type push;
   rsp_item_type   rsp_item;
   logic           space_two;
   logic           take;

   assign req_stall = !space_two;
   assign take      = req_valid && space_two;

   tas_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tas_core u_core (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .kind        (req_kind),
      .elapsed_ms  (req_elapsed_ms),
      .lifter_idle (req_lifter_idle),
      .link_up     (req_link_up),
      .cfg         (cfg),
      .push        (push)
   );

   tas_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_two (space_two),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_command         = rsp_item.command;
   assign rsp_target_position = rsp_item.target_position;
   assign rsp_accepted        = rsp_item.accepted;
   assign rsp_initialized     = rsp_item.initialized;
   assign rsp_last            = rsp_item.last;

endmodule
